>>> rtl/pfm_pkg.sv
`default_nettype none
package pfm_pkg;

    // Field and datapath widths
    localparam int SPEED_W      = 16;
    localparam int ANGLE_IN_W   = 17;
    localparam int DUR_W        = 16;
    localparam int GRAV_W       = 16;
    localparam int ANG_W        = 32;
    localparam int DIV_W        = 45;
    localparam int TAB_LEN      = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // Constants of the angle path
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam logic [17:0] FULL_TURN_Q8    = 18'd92160;
    localparam logic [17:0] HALF_TURN_Q8    = 18'd46080;
    localparam logic [17:0] QUARTER_TURN_Q8 = 18'd23040;

    // Register map
    localparam logic REG_GRAVITY = 1'b0;
    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 16'd2511;

    // Per-item control carried along the angle and CORDIC stages
    typedef struct packed {
        logic                 sneg;
        logic                 cneg;
        logic [SPEED_W-1:0]   speed;
        logic [DUR_W-1:0]     dur;
    } pfm_item_t;

    // Arctangent table, Q2.30 radians
    function automatic logic [ANG_W-1:0] atan_q30(input int unsigned idx);
        logic [ANG_W-1:0] r;
        case (idx)
            0:  r = 32'h3243F6A8;
            1:  r = 32'h1DAC6705;
            2:  r = 32'h0FADBAFC;
            3:  r = 32'h07F56EA6;
            4:  r = 32'h03FEAB76;
            5:  r = 32'h01FFD55B;
            6:  r = 32'h00FFFAAA;
            7:  r = 32'h007FFF55;
            8:  r = 32'h003FFFEA;
            9:  r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            23: r = 32'h0000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/pfm_angle.sv
`default_nettype none
module pfm_angle (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [pfm_pkg::ANGLE_IN_W-1:0]  raw_angle,
    input  wire logic [pfm_pkg::SPEED_W-1:0]     speed,
    input  wire logic [pfm_pkg::DUR_W-1:0]       dur,
    output logic                                 out_valid,
    output pfm_pkg::pfm_item_t                   out_item,
    output logic signed [pfm_pkg::ANG_W-1:0]     out_z
);
    import pfm_pkg::*;

    logic [17:0]      mag0, mag1, mag2;
    logic             sn1, cn2;
    logic             v1_reg, v2_reg;
    logic [14:0]      mag_reg;
    pfm_item_t        item1_reg, item2_reg;
    logic [39:0]      prod;
    logic [ANG_W-1:0] z_reg;

    // Fold into the first quadrant
    always_comb begin
        mag0 = raw_angle[16] ? (18'h20000 - {1'b0, raw_angle}) : {1'b0, raw_angle};
        sn1  = raw_angle[16];
        mag1 = mag0;
        if (mag0 > HALF_TURN_Q8) begin
            mag1 = FULL_TURN_Q8 - mag0;
            sn1  = ~raw_angle[16];
        end
        mag2 = mag1;
        cn2  = 1'b0;
        if (mag1 > QUARTER_TURN_Q8) begin
            mag2 = HALF_TURN_Q8 - mag1;
            cn2  = 1'b1;
        end
    end

    // Folded degrees times the Q30 radian factor, full 40-bit product
    assign prod = {25'd0, mag_reg} * {15'd0, DEG_TO_RAD_Q30};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Payload: fold, then degrees to Q30 radians
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg         <= mag2[14:0];
            item1_reg.sneg  <= sn1;
            item1_reg.cneg  <= cn2;
            item1_reg.speed <= speed;
            item1_reg.dur   <= dur;
            item2_reg       <= item1_reg;
            z_reg           <= prod[39:8];
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_z     = $signed(z_reg);

endmodule
`default_nettype wire

>>> rtl/pfm_cordic.sv
`default_nettype none
module pfm_cordic #(
    parameter int STEPS = pfm_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire pfm_pkg::pfm_item_t              in_item,
    input  wire logic signed [pfm_pkg::ANG_W-1:0] in_z,
    output logic                                 out_valid,
    output pfm_pkg::pfm_item_t                   out_item,
    output logic signed [pfm_pkg::ANG_W-1:0]     out_sin,
    output logic signed [pfm_pkg::ANG_W-1:0]     out_cos
);
    import pfm_pkg::*;

    logic signed [ANG_W-1:0] x_w [STEPS+1];
    logic signed [ANG_W-1:0] y_w [STEPS+1];
    logic signed [ANG_W-1:0] z_w [STEPS+1];
    logic                    v_w [STEPS+1];
    pfm_item_t               it_w [STEPS+1];

    assign x_w[0]  = CORDIC_GAIN;
    assign y_w[0]  = '0;
    assign z_w[0]  = in_z;
    assign v_w[0]  = in_valid;
    assign it_w[0] = in_item;

    // One rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [ANG_W-1:0] x_reg, y_reg, z_reg;
        logic                    v_reg;
        pfm_item_t               it_reg;
        logic signed [ANG_W-1:0] dx, dy, at;

        assign dx = y_w[i] >>> i;
        assign dy = x_w[i] >>> i;
        assign at = $signed(atan_q30((i < TAB_LEN) ? i : TAB_LEN));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_w[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                it_reg <= it_w[i];
                if (!z_w[i][ANG_W-1]) begin
                    x_reg <= x_w[i] - dx;
                    y_reg <= y_w[i] + dy;
                    z_reg <= z_w[i] - at;
                end else begin
                    x_reg <= x_w[i] + dx;
                    y_reg <= y_w[i] - dy;
                    z_reg <= z_w[i] + at;
                end
            end
        end

        assign x_w[i+1]  = x_reg;
        assign y_w[i+1]  = y_reg;
        assign z_w[i+1]  = z_reg;
        assign v_w[i+1]  = v_reg;
        assign it_w[i+1] = it_reg;
    end

    assign out_valid = v_w[STEPS];
    assign out_item  = it_w[STEPS];
    assign out_sin   = y_w[STEPS];
    assign out_cos   = x_w[STEPS];

endmodule
`default_nettype wire

>>> rtl/pfm_div.sv
`default_nettype none
module pfm_div #(
    parameter int DW = pfm_pkg::DIV_W,
    parameter int SW = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [DW-1:0]                 num_a,
    input  wire logic [DW-1:0]                 num_b,
    input  wire logic [pfm_pkg::GRAV_W-1:0]    divisor,
    input  wire logic [SW-1:0]                 side_in,
    output logic                               out_valid,
    output logic [DW-1:0]                      quo_a,
    output logic [DW-1:0]                      quo_b,
    output logic [SW-1:0]                      side_out
);
    import pfm_pkg::*;

    logic [GRAV_W-1:0] ra_w [DW+1];
    logic [GRAV_W-1:0] rb_w [DW+1];
    logic [DW-1:0]     qa_w [DW+1];
    logic [DW-1:0]     qb_w [DW+1];
    logic [SW-1:0]     s_w  [DW+1];
    logic              v_w  [DW+1];

    assign ra_w[0] = '0;
    assign rb_w[0] = '0;
    assign qa_w[0] = num_a;
    assign qb_w[0] = num_b;
    assign s_w[0]  = side_in;
    assign v_w[0]  = in_valid;

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [GRAV_W:0]   ta, tb, dz;
        logic              ga, gb;
        logic [GRAV_W-1:0] ra_reg, rb_reg;
        logic [DW-1:0]     qa_reg, qb_reg;
        logic [SW-1:0]     s_reg;
        logic              v_reg;
        logic [GRAV_W:0]   da, db;

        assign dz = {1'b0, divisor};
        assign ta = {ra_w[k], qa_w[k][DW-1]};
        assign tb = {rb_w[k], qb_w[k][DW-1]};
        assign ga = (ta >= dz);
        assign gb = (tb >= dz);
        assign da = ga ? (ta - dz) : ta;
        assign db = gb ? (tb - dz) : tb;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ra_reg <= da[GRAV_W-1:0];
                rb_reg <= db[GRAV_W-1:0];
                qa_reg <= {qa_w[k][DW-2:0], ga};
                qb_reg <= {qb_w[k][DW-2:0], gb};
                s_reg  <= s_w[k];
            end
        end

        assign ra_w[k+1] = ra_reg;
        assign rb_w[k+1] = rb_reg;
        assign qa_w[k+1] = qa_reg;
        assign qb_w[k+1] = qb_reg;
        assign s_w[k+1]  = s_reg;
        assign v_w[k+1]  = v_reg;
    end

    assign out_valid = v_w[DW];
    assign quo_a     = qa_w[DW];
    assign quo_b     = qb_w[DW];
    assign side_out  = s_w[DW];

endmodule
`default_nettype wire

>>> rtl/projectile_flight_metrics_top.sv
// Projectile flight metrics: time of flight, ground range and peak height.
// Input stream (s_*): one launch record per request, tdata holds speed,
// elevation angle and duration. Output stream (m_*): one result per record,
// tdata holds flight time, ground range and peak height, in input order.
// Gravity is written through the APB port at address 0; the user must write
// it only while the stream is idle, as the block does not enforce this. A
// gravity of zero acts as one LSB. Pipeline: 2 fold/radian stages, one CORDIC
// stage per rotation, 3 product stages, 45 divider stages, 1 output stage.
// Throughput: one record per cycle unless the receiver stalls. The divider
// costs one stage per quotient bit, the CORDIC one stage per rotation.
// Reset clears every valid bit and sets gravity to its default.
// A receiver stall freezes the whole pipeline in place: s_tready follows
// m_tready while a result is held, and nothing is lost or repeated.
`default_nettype none
module projectile_flight_metrics_top #(
    parameter int CORDIC_STEPS = pfm_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // launch_speed [15:0], elevation_degrees [32:16], flight_duration [48:33]
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // flight_time [31:0], ground_range [63:32], peak_height [94:64]
    output logic [95:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pfm_pkg::*;

    localparam int SIDE_W = 33;

    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
        logic [31:0] r;
        if (!neg) begin
            r = (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        end else if (m >= 64'h80000000) begin
            r = 32'h80000000;
        end else begin
            r = 32'd0 - m[31:0];
        end
        return r;
    endfunction

    logic [GRAV_W-1:0] gravity_reg;
    logic [GRAV_W-1:0] g_eff;
    logic              adv;

    logic                    a_valid, c_valid;
    pfm_item_t               a_item, c_item;
    logic signed [ANG_W-1:0] a_z, c_sin, c_cos;

    logic signed [ANG_W-1:0] s_sgn, c_sgn;
    logic                    p1_v_reg, p2_v_reg, p3_v_reg;
    logic signed [48:0]      vs_reg, vc_reg;
    logic [DUR_W-1:0]        dur1_reg, dur2_reg;
    logic [48:0]             vsm, vcm;
    logic                    vsn2_reg, vcn2_reg, vsn3_reg, vcn3_reg;
    logic [34:0]             fnum2_reg, fnum3_reg;
    logic [29:0]             q_reg;
    logic [47:0]             vcm_reg;
    logic [59:0]             qq_reg;
    logic [63:0]             rr_reg;

    logic [DIV_W-1:0]  div_a, div_b, quo_a, quo_b;
    logic [SIDE_W-1:0] side_in, side_out;
    logic              d_valid;

    logic              m_valid_reg;
    logic [31:0]       ft_reg, gr_reg;
    logic [30:0]       ph_reg;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {16'd0, gravity_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= GRAVITY_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_GRAVITY) begin
            gravity_reg <= pwdata[GRAV_W-1:0];
        end
    end
    assign g_eff = (gravity_reg == '0) ? 16'd1 : gravity_reg;

    // Global advance: the pipeline moves unless a held result is stalled
    assign adv      = ~m_valid_reg | m_tready;
    assign s_tready = adv;

    pfm_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .raw_angle (s_tdata[32:16]),
        .speed     (s_tdata[15:0]),
        .dur       (s_tdata[48:33]),
        .out_valid (a_valid),
        .out_item  (a_item),
        .out_z     (a_z)
    );

    pfm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a_valid),
        .in_item   (a_item),
        .in_z      (a_z),
        .out_valid (c_valid),
        .out_item  (c_item),
        .out_sin   (c_sin),
        .out_cos   (c_cos)
    );

    // Signed sine and cosine
    assign s_sgn = c_item.sneg ? -c_sin : c_sin;
    assign c_sgn = c_item.cneg ? -c_cos : c_cos;

    // Magnitudes of the products
    assign vsm = vs_reg[48] ? 49'(-vs_reg) : 49'(vs_reg);
    assign vcm = vc_reg[48] ? 49'(-vc_reg) : 49'(vc_reg);

    // Product stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end else if (adv) begin
            p1_v_reg <= c_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    // Speed products, magnitudes, then square and range product
    always_ff @(posedge aclk) begin
        if (adv) begin
            vs_reg    <= $signed({1'b0, c_item.speed}) * s_sgn;
            vc_reg    <= $signed({1'b0, c_item.speed}) * c_sgn;
            dur1_reg  <= c_item.dur;
            vsn2_reg  <= vs_reg[48];
            vcn2_reg  <= vc_reg[48];
            fnum2_reg <= vsm[47:13];
            q_reg     <= vsm[47:18];
            vcm_reg   <= vcm[47:0];
            dur2_reg  <= dur1_reg;
            vsn3_reg  <= vsn2_reg;
            vcn3_reg  <= vcn2_reg;
            fnum3_reg <= fnum2_reg;
            qq_reg    <= q_reg * q_reg;
            rr_reg    <= vcm_reg * dur2_reg;
        end
    end

    assign div_a   = {{(DIV_W-35){1'b0}}, fnum3_reg};
    assign div_b   = {2'd0, qq_reg[59:17]};
    assign side_in = {vsn3_reg, sat32(vcn3_reg, {30'd0, rr_reg[63:30]})};

    pfm_div #(.DW(DIV_W), .SW(SIDE_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p3_v_reg),
        .num_a     (div_a),
        .num_b     (div_b),
        .divisor   (g_eff),
        .side_in   (side_in),
        .out_valid (d_valid),
        .quo_a     (quo_a),
        .quo_b     (quo_b),
        .side_out  (side_out)
    );

    // Output register with saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ft_reg <= sat32(side_out[32], {{(64-DIV_W){1'b0}}, quo_a});
            gr_reg <= side_out[31:0];
            ph_reg <= (quo_b > 45'h7FFFFFFF) ? 31'h7FFFFFFF : quo_b[30:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, ph_reg, gr_reg, ft_reg};

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import pfm_pkg::*;

    localparam int STEPS    = CORDIC_STEPS_DEF;
    localparam int LATENCY  = STEPS + 51;
    localparam int N_RANDOM = 1850;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [15:0] speed;
        logic [16:0] angle;
        logic [15:0] dur;
    } launch_t;

    typedef struct packed {
        logic [31:0] tof;
        logic [31:0] rng;
        logic [30:0] peak;
    } metrics_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    projectile_flight_metrics_top DUT (.*);

    always #10 aclk = ~aclk;

    launch_t  launch_q[$];
    metrics_t metrics_q[$];
    logic [15:0] grav_model = GRAVITY_RESET;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_sender = 1'b0;
    int  errors = 0;
    longint cycles = 0;

    // Arithmetic shift right with floor
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] clamp_s32(bit neg, logic [63:0] m);
        if (!neg) return (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        if (m >= 64'h80000000) return 32'h80000000;
        return 32'(-m);
    endfunction

    function automatic metrics_t flight_metrics(launch_t it);
        metrics_t r;
        logic [63:0] g, mag, m, q, avs, avc;
        bit sneg, cneg;
        longint x, y, z, dx, dy, s, c, vs, vc;
        g = (grav_model == 0) ? 64'd1 : 64'(grav_model);
        sneg = it.angle[16];
        cneg = 1'b0;
        mag = sneg ? 64'h20000 - 64'(it.angle) : 64'(it.angle);
        if (mag > 64'(HALF_TURN_Q8)) begin
            mag = 64'(FULL_TURN_Q8) - mag;
            sneg = !sneg;
        end
        if (mag > 64'(QUARTER_TURN_Q8)) begin
            mag = 64'(HALF_TURN_Q8) - mag;
            cneg = 1'b1;
        end
        z = longint'((mag * 64'(DEG_TO_RAD_Q30)) >> 8);
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_q30(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_q30(i));
            end
        end
        s = sneg ? -y : y;
        c = cneg ? -x : x;
        vs = longint'(it.speed) * s;
        vc = longint'(it.speed) * c;
        avs = (vs < 0) ? 64'(-vs) : 64'(vs);
        avc = (vc < 0) ? 64'(-vc) : 64'(vc);
        m = (2 * avs) / (g << 14);
        r.tof = clamp_s32(vs < 0, m);
        m = (avc * 64'(it.dur)) >> 30;
        r.rng = clamp_s32(vc < 0, m);
        q = avs >> 18;
        m = (q * q) / (g << 17);
        r.peak = (m > 64'h7FFFFFFF) ? 31'h7FFFFFFF : m[30:0];
        return r;
    endfunction

    // Driver: presents queued launch records
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                metrics_q.push_back(flight_metrics(launch_q.pop_front()));
            end
            if ((!s_tvalid || s_tready) || !s_tvalid) begin
                if (s_tvalid && !s_tready) begin
                    // hold current request
                end else if (launch_q.size() > 0 && !hold_sender
                             && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, launch_q[0].dur, launch_q[0].angle,
                                 launch_q[0].speed};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares results and randomizes backpressure
    always @(posedge aclk) begin
        metrics_t got, want;
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.tof  = m_tdata[31:0];
                got.rng  = m_tdata[63:32];
                got.peak = m_tdata[94:64];
                if (metrics_q.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    want = metrics_q.pop_front();
                    if (got.tof !== want.tof) begin
                        $error("flight_time exp %h got %h", want.tof, got.tof);
                        errors++;
                    end
                    if (got.rng !== want.rng) begin
                        $error("ground_range exp %h got %h", want.rng, got.rng);
                        errors++;
                    end
                    if (got.peak !== want.peak) begin
                        $error("peak_height exp %h got %h", want.peak, got.peak);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Timeout
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_gravity(logic [15:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(REG_GRAVITY) << 2; pwdata <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        grav_model = val;
    endtask

    task automatic drain();
        while (launch_q.size() > 0 || metrics_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic launch_t random_launch();
        launch_t it;
        it.speed = 16'($urandom);
        it.dur = 16'($urandom);
        case ($urandom_range(9))
            0: it.angle = 17'($urandom);  // full 17-bit range, wraps by a turn
            1: it.angle = 17'($urandom_range(4) * 23040 - 46080);
            default: it.angle = 17'(int'($urandom_range(92160)) - 46080);
        endcase
        if ($urandom_range(7) == 0) it.speed = 16'($urandom_range(255));
        return it;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) launch_q.push_back(random_launch());
    endtask

    initial begin
        logic [16:0] dir_angles[9] = '{17'd0, 17'd23040, 17'd46080,
            17'h1FFFF & -17'd23040, 17'h1FFFF & -17'd46080, 17'h10000, 17'h0FFFF,
            17'd11520, 17'h1FFFF};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes at reset gravity, then zero and max gravity
        foreach (dir_angles[i])
            launch_q.push_back('{16'hFFFF, dir_angles[i], 16'hFFFF});
        launch_q.push_back('{16'h0000, 17'd11520, 16'hFFFF});
        launch_q.push_back('{16'h0100, 17'd11520, 16'h0000});
        launch_q.push_back('{16'h8000, 17'd5000, 16'h0100});
        drain();
        write_gravity(16'd0);
        launch_q.push_back('{16'hFFFF, 17'd23040, 16'hFFFF});
        launch_q.push_back('{16'hFFFF, 17'h1FFFF & -17'd11520, 16'hFFFF});
        launch_q.push_back('{16'h0001, 17'd1, 16'h0001});
        drain();
        write_gravity(16'hFFFF);
        launch_q.push_back('{16'hFFFF, 17'd23040, 16'hFFFF});
        launch_q.push_back('{16'h1234, 17'd7000, 16'h4321});
        drain();

        // Random phases across several gravity settings
        write_gravity(16'd2511);
        send_idle_pct = 27; recv_idle_pct = 45;
        run_random(300);
        // Sender holds off until every result is back
        while (launch_q.size() > 150) @(posedge aclk);
        hold_sender = 1'b1;
        while (metrics_q.size() > 0 || s_tvalid) @(posedge aclk);
        hold_sender = 1'b0;
        drain();
        write_gravity(16'(1 + $urandom_range(4000)));
        run_random(350);
        drain();
        write_gravity(16'd1);
        send_idle_pct = 45; recv_idle_pct = 27;
        run_random(400);
        drain();
        write_gravity(16'($urandom));
        run_random(300);
        drain();
        write_gravity(16'd2511);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(500);
        drain();

        if (errors == 0 && metrics_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/pfm_pkg.sv
rtl/pfm_angle.sv
rtl/pfm_cordic.sv
rtl/pfm_div.sv
rtl/projectile_flight_metrics_top.sv
dv/testbench.sv
